// ===== sv/itoa_pkg.sv =====
// itoa_pkg: types and constants shared by the signed integer to decimal text block
// used by itoa_ctrl, itoa_datapath and signed_int_to_decimal_ascii_top; no dependencies
package itoa_pkg;

	localparam int unsigned ValueWidth  = 32;
	localparam int unsigned CharWidth   = 6;
	localparam int unsigned OutBytes    = 1;
	localparam int unsigned NumDigits   = 10;
	localparam int unsigned BcdWidth    = 4 * NumDigits;
	localparam int unsigned BitsPerStep = 4;
	localparam int unsigned NumSteps    = ValueWidth / BitsPerStep;
	localparam int unsigned StepWidth   = $clog2(NumSteps);
	localparam int unsigned IdxWidth    = $clog2(NumDigits);

	localparam logic [CharWidth-1:0] CharMinus = 6'd45;
	localparam logic [CharWidth-1:0] CharZero  = 6'd48;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_FIND,
		ST_SIGN,
		ST_DIGITS
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic find;
		logic emit_sign;
		logic emit_digit;
	} itoa_cmd_t;

	typedef struct packed {
		logic conv_last;
		logic negative;
		logic idx_zero;
		logic out_free;
	} itoa_status_t;

endpackage

// ===== sv/itoa_ctrl.sv =====
// itoa_ctrl: controller state machine sequencing load, conversion and character output
// depends on itoa_pkg; drives itoa_datapath through itoa_cmd_t
module itoa_ctrl import itoa_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  itoa_status_t status,
	output itoa_cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.step = 1'b1;
				if (status.conv_last) begin
					state_d = ST_FIND;
				end
			end
			ST_FIND: begin
				cmd.find = 1'b1;
				state_d  = status.negative ? ST_SIGN : ST_DIGITS;
			end
			ST_SIGN: begin
				if (status.out_free) begin
					cmd.emit_sign = 1'b1;
					state_d       = ST_DIGITS;
				end
			end
			ST_DIGITS: begin
				if (status.out_free) begin
					cmd.emit_digit = 1'b1;
					if (status.idx_zero) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/itoa_datapath.sv =====
// itoa_datapath: magnitude, shift-and-add-3 bcd register, digit pointer and output register
// depends on itoa_pkg; commanded by itoa_ctrl
module itoa_datapath import itoa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [ValueWidth-1:0] value,
	input  itoa_cmd_t             cmd,
	output itoa_status_t          status,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [CharWidth-1:0]  text_char,
	output logic                  last_char
);

	logic [ValueWidth-1:0] mag_q;
	logic                  neg_q;
	logic [BcdWidth-1:0]   bcd_q;
	logic [StepWidth-1:0]  cnt_q;
	logic [IdxWidth-1:0]   idx_q;
	logic                  out_valid_q;
	logic [CharWidth-1:0]  char_q;
	logic                  last_q;

	logic [ValueWidth-1:0] mag_next;
	logic [BcdWidth-1:0]   bcd_next;
	logic [IdxWidth-1:0]   msd_idx;
	logic [3:0]            cur_digit;

	// several shift-and-add-3 iterations per cycle
	always_comb begin
		bcd_next = bcd_q;
		mag_next = mag_q;
		for (int s = 0; s < BitsPerStep; s++) begin
			for (int d = 0; d < NumDigits; d++) begin
				if (bcd_next[d*4 +: 4] >= 4'd5) begin
					bcd_next[d*4 +: 4] = bcd_next[d*4 +: 4] + 4'd3;
				end
			end
			bcd_next = {bcd_next[BcdWidth-2:0], mag_next[ValueWidth-1]};
			mag_next = {mag_next[ValueWidth-2:0], 1'b0};
		end
	end

	// most significant nonzero digit, zero when all digits are zero
	always_comb begin
		msd_idx = '0;
		for (int d = 0; d < NumDigits; d++) begin
			if (bcd_q[d*4 +: 4] != 4'd0) begin
				msd_idx = IdxWidth'(d);
			end
		end
	end

	assign cur_digit = bcd_q[idx_q*4 +: 4];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= value[ValueWidth-1];
			mag_q <= value[ValueWidth-1] ? (ValueWidth'(0) - value) : value;
			bcd_q <= '0;
		end else if (cmd.step) begin
			mag_q <= mag_next;
			bcd_q <= bcd_next;
		end
		if (cmd.emit_sign) begin
			char_q <= CharMinus;
			last_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q <= CharZero + {2'b00, cur_digit};
			last_q <= (idx_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.find) begin
				idx_q <= msd_idx;
			end else if (cmd.emit_digit && idx_q != '0) begin
				idx_q <= idx_q - 1'b1;
			end
			if (cmd.emit_sign || cmd.emit_digit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.conv_last = (cnt_q == StepWidth'(NumSteps - 1));
	assign status.negative  = neg_q;
	assign status.idx_zero  = (idx_q == '0);
	assign status.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign text_char = char_q;
	assign last_char = last_q;

endmodule

// ===== sv/signed_int_to_decimal_ascii_top.sv =====
// first character, minus sign or digit alike, is output after conversion and digit search
// one number at a time: the next input is taken once the last character is registered
// bcd conversion 4 bits per cycle, then one character per cycle out unless stalled
// the output register lets the last character wait while the next number is taken in
// reset: arst_n asynchronous active low, clears the state machine and output valid
module signed_int_to_decimal_ascii_top import itoa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] value
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [5:0] text_char, [7:6] zero
	output logic        m_axis_tlast
);

	itoa_cmd_t            cmd;
	itoa_status_t         status;
	logic [CharWidth-1:0] text_char;

	itoa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	itoa_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (s_axis_tdata),
		.cmd       (cmd),
		.status    (status),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.text_char (text_char),
		.last_char (m_axis_tlast)
	);

	assign m_axis_tdata = {(8*OutBytes - CharWidth)'(0), text_char};

endmodule

// ===== sv/itoa_checker.sv =====
// itoa_checker: port-level assertions for signed_int_to_decimal_ascii_top
// bound to the top level below; no package dependency
module itoa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [31:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic        m_axis_tlast
);

	// stalled output transfer holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output changed while stalled");

	// only minus sign or digits leave
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[7:6] == 2'b00 &&
			(m_axis_tdata[5:0] == 6'd45 ||
			(m_axis_tdata[5:0] >= 6'd48 && m_axis_tdata[5:0] <= 6'd57)))
		else $error("illegal character");

	// minus sign never ends a number
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[5:0] == 6'd45 |-> !m_axis_tlast)
		else $error("minus sign marked last");

	// one number at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken during conversion");

endmodule

bind signed_int_to_decimal_ascii_top itoa_checker u_itoa_checker (.*);

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking bench for signed_int_to_decimal_ascii_top, signed integer to decimal text
// directed corner values, then random values under several ready/valid idling phases
// depends on itoa_pkg and signed_int_to_decimal_ascii_top
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import itoa_pkg::*;

	typedef struct packed {
		logic [CharWidth-1:0] text_char;
		logic                 last_char;
	} ascii_char_t;

	class text_scoreboard;
		ascii_char_t expected_chars[$];
		int errors = 0;

		function void note_value(logic [31:0] value);
			logic [31:0] mag;
			logic [3:0] digits[10];
			int nd;
			ascii_char_t c;
			nd = 0;
			mag = value[31] ? (32'd0 - value) : value;
			if (mag == 32'd0) begin
				digits[0] = 4'd0;
				nd = 1;
			end
			while (mag != 32'd0) begin
				digits[nd] = 4'(mag % 32'd10);
				mag = mag / 32'd10;
				nd++;
			end
			if (value[31]) begin
				c.text_char = CharMinus;
				c.last_char = 1'b0;
				expected_chars.push_back(c);
			end
			for (int k = nd - 1; k >= 0; k--) begin
				c.text_char = CharZero + CharWidth'(digits[k]);
				c.last_char = (k == 0);
				expected_chars.push_back(c);
			end
		endfunction

		function void check_char(logic [CharWidth-1:0] text_char, logic last_char);
			ascii_char_t exp_c;
			if (expected_chars.size() == 0) begin
				$error("text_char: unexpected transfer, actual %0d", text_char);
				errors++;
				return;
			end
			exp_c = expected_chars.pop_front();
			if (text_char !== exp_c.text_char) begin
				$error("text_char: expected %0d, actual %0d", exp_c.text_char, text_char);
				errors++;
			end
			if (last_char !== exp_c.last_char) begin
				$error("last_char: expected %0d, actual %0d", exp_c.last_char, last_char);
				errors++;
			end
		endfunction

		function bit empty();
			return expected_chars.size() == 0;
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = 32'd0;  // [31:0] value
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;          // [5:0] text_char, [7:6] zero
	logic        m_axis_tlast;

	int idle_pct = 0;
	int stall_pct = 0;
	text_scoreboard decimal_text = new();

	signed_int_to_decimal_ascii_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				decimal_text.note_value(s_axis_tdata);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				decimal_text.check_char(m_axis_tdata[CharWidth-1:0], m_axis_tlast);
			end
		end
	end

	task automatic send_value(logic [31:0] value);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= $urandom;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic wait_drained();
		while (!decimal_text.empty()) @(posedge clk);
	endtask

	function automatic logic [31:0] random_value();
		int unsigned ndig;
		longint pow;
		longint mag;
		if ($urandom_range(3) == 0) begin
			return $urandom;
		end
		ndig = $urandom_range(1, 10);
		pow = 1;
		for (int i = 0; i < ndig; i++) begin
			pow = pow * 10;
		end
		mag = longint'({$urandom, $urandom} & 64'h3fff_ffff_ffff) % pow;
		if (mag > 64'd2147483648) begin
			mag = mag % 64'd2147483649;
		end
		return $urandom_range(1) ? 32'(-mag) : 32'(mag);
	endfunction

	initial begin
		logic [31:0] corner_values[$];
		corner_values = '{32'd0, 32'd1, -32'd1, 32'd9, 32'd10, -32'd10, 32'd99, 32'd100,
			32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'd1000000000, 32'd999999999,
			-32'd999999999, 32'd123456789, -32'd5, 32'd1000000007, -32'd1000000000,
			32'haaaa_aaaa, 32'h5555_5555};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corner_values[i]) send_value(corner_values[i]);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 72; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 72; end
				default: begin idle_pct = 16; stall_pct = 16; end
			endcase
			repeat (100) send_value(random_value());
		end
		s_axis_tvalid <= 1'b0;
		@(posedge clk);

		wait_drained();
		repeat (40) @(posedge clk);
		if (decimal_text.errors == 0 && decimal_text.empty()) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
